// ===== sv/mhb_pkg.sv =====
package mhb_pkg;

  localparam int ROT_W      = 24;
  localparam int INT_W      = 32;
  localparam int MET_W      = 24;
  localparam int RAD_W      = 16;
  localparam int CODE_W     = 12;
  localparam int PROD_W     = MET_W + RAD_W;
  localparam int POW5_W     = 21;
  localparam int MUL_W      = PROD_W + POW5_W;
  localparam int DIV_W      = 32;
  localparam int NUM_SHIFT  = 11;
  localparam int HI_LSB     = NUM_SHIFT + MET_W;
  localparam int HI_W       = MUL_W - HI_LSB;
  localparam int STEP_W     = 5;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;
  localparam int IN_TDATA_W = 104;
  localparam int OUT_TDATA_W = 40;

  localparam logic [POW5_W-1:0] POW5_9       = 21'd1953125;
  localparam logic [INT_W-1:0]  MIN_INTERVAL = 32'd1000;

  localparam logic [CFG_IDX_W-1:0] REG_BLANK_ENABLE   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BALL_RADIUS    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD_HIGH = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD_LOW  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_VISIBLE_CODE   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_BLANK_CODE     = 3'd5;

  typedef struct packed {
    logic [DIV_W-1:0] rem;
    logic [MET_W-1:0] low;
    logic [DIV_W-1:0] dvs;
  } div_req_t;

endpackage

// ===== sv/mhb_const_mul.sv =====
module mhb_const_mul (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [mhb_pkg::PROD_W-1:0]   operand,
  output logic                         done,
  output logic [mhb_pkg::MUL_W-1:0]    product
);

  logic                             busy_r;
  logic                             done_r;
  logic [mhb_pkg::STEP_W-1:0]       idx_r;
  logic [mhb_pkg::MUL_W-1:0]        acc_r;
  logic [mhb_pkg::MUL_W-1:0]        opd_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      idx_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        idx_r  <= '0;
      end else if (busy_r) begin
        idx_r <= idx_r + 1'b1;
        if (idx_r == mhb_pkg::STEP_W'(mhb_pkg::POW5_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // shift-add over the constant bits
  always_ff @(posedge clk) begin
    if (start) begin
      acc_r <= '0;
      opd_r <= {{mhb_pkg::POW5_W{1'b0}}, operand};
    end else if (busy_r) begin
      if (mhb_pkg::POW5_9[idx_r]) begin
        acc_r <= acc_r + opd_r;
      end
      opd_r <= {opd_r[mhb_pkg::MUL_W-2:0], 1'b0};
    end
  end

  assign done    = done_r;
  assign product = acc_r;

endmodule

// ===== sv/mhb_div.sv =====
module mhb_div (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  mhb_pkg::div_req_t           req,
  output logic                        done,
  output logic [mhb_pkg::MET_W-1:0]   quo
);

  logic                            busy_r;
  logic                            done_r;
  logic [mhb_pkg::STEP_W-1:0]      cnt_r;
  logic [mhb_pkg::DIV_W-1:0]       rem_r;
  logic [mhb_pkg::MET_W-1:0]       low_r;
  logic [mhb_pkg::MET_W-1:0]       quo_r;
  logic [mhb_pkg::DIV_W-1:0]       dvs_r;
  logic [mhb_pkg::DIV_W:0]         trial;
  logic [mhb_pkg::DIV_W:0]         diff;
  logic                            fits;
  logic                            sat;

  assign sat   = req.rem >= req.dvs;
  assign trial = {rem_r, low_r[mhb_pkg::MET_W-1]};
  assign diff  = trial - {1'b0, dvs_r};
  assign fits  = trial >= {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        cnt_r <= '0;
        if (sat) begin
          done_r <= 1'b1;
        end else begin
          busy_r <= 1'b1;
        end
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == mhb_pkg::STEP_W'(mhb_pkg::MET_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // restoring division, one quotient bit per cycle
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= req.rem;
      low_r <= req.low;
      dvs_r <= req.dvs;
      quo_r <= sat ? '1 : '0;
    end else if (busy_r) begin
      rem_r <= fits ? diff[mhb_pkg::DIV_W-1:0] : trial[mhb_pkg::DIV_W-1:0];
      low_r <= {low_r[mhb_pkg::MET_W-2:0], 1'b0};
      quo_r <= {quo_r[mhb_pkg::MET_W-2:0], fits};
    end
  end

  assign done = done_r;
  assign quo  = quo_r;

endmodule

// ===== sv/motion_hysteresis_blanker_core.sv =====
// A taken sample runs the serial constant multiply, the metric division and the window push;
// every item then runs the mean division (skipped while the window is empty) and the decision;
// a saturated division skips its iterations. One item at a time; the divider serves both metric
// and mean. A new item is accepted while the previous result still waits in the output register.
// Reset (synchronous, rst_n low) clears the window and held index and resets state, output valid
// and config; datapath regs and window entries hold no reset value, entries read only once written
module motion_hysteresis_blanker_core #(
  parameter int WINDOW_DEPTH = 16,
  parameter int INDEX_MAX    = 4095
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // rotation_x, rotation_y, rotation_z, interval_ns
  input  logic [mhb_pkg::IN_TDATA_W-1:0]     in_tdata,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // sample_taken, motion_mean, index_value, index_written, zero fill
  output logic [mhb_pkg::OUT_TDATA_W-1:0]    out_tdata,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [mhb_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [mhb_pkg::CFG_DATA_W-1:0]     cfg_data
);

  localparam int HEAD_W = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
  localparam int FILL_W = $clog2(WINDOW_DEPTH + 1);
  localparam int SUM_W  = mhb_pkg::MET_W + FILL_W;

  typedef enum logic [7:0] {
    S_IDLE   = 8'b0000_0001,
    S_PROD   = 8'b0000_0010,
    S_MUL    = 8'b0000_0100,
    S_QDIV   = 8'b0000_1000,
    S_PUSH   = 8'b0001_0000,
    S_MEANL  = 8'b0010_0000,
    S_MEAN   = 8'b0100_0000,
    S_DECIDE = 8'b1000_0000
  } state_t;

  state_t state_r, state_nxt;

  logic                             blank_en_r;
  logic [mhb_pkg::RAD_W-1:0]        radius_r;
  logic [mhb_pkg::MET_W-1:0]        th_hi_r;
  logic [mhb_pkg::MET_W-1:0]        th_lo_r;
  logic [mhb_pkg::CODE_W-1:0]       vis_code_r;
  logic [mhb_pkg::CODE_W-1:0]       blk_code_r;
  logic [mhb_pkg::CODE_W-1:0]       held_r;

  logic [mhb_pkg::MET_W-1:0]        win_mem [WINDOW_DEPTH];
  logic [mhb_pkg::MET_W-1:0]        old_r;
  logic [SUM_W-1:0]                 sum_r;
  logic [HEAD_W-1:0]                head_r;
  logic [FILL_W-1:0]                fill_r;

  logic [mhb_pkg::MET_W-1:0]        mx_r;
  logic [mhb_pkg::INT_W-1:0]        interval_r;
  logic                             taken_r;
  logic [mhb_pkg::MET_W-1:0]        q_r;
  logic [mhb_pkg::MET_W-1:0]        mean_r;

  logic                             out_valid_r;
  logic [mhb_pkg::OUT_TDATA_W-1:0]  out_data_r;

  logic                             in_acc;
  logic                             cfg_acc;
  logic                             cfg_clear;
  logic [mhb_pkg::MET_W-1:0]        ax, ay, az, mx_nxt;
  logic [mhb_pkg::INT_W-1:0]        in_interval;
  logic [mhb_pkg::CODE_W-1:0]       code_in;
  logic [mhb_pkg::CODE_W-1:0]       code_clamped;

  logic                             mul_start;
  logic [mhb_pkg::PROD_W-1:0]       mul_opd;
  logic                             mul_done;
  logic [mhb_pkg::MUL_W-1:0]        mul_prod;
  logic                             div_start;
  logic                             div_done;
  logic [mhb_pkg::MET_W-1:0]        div_quo;
  mhb_pkg::div_req_t                div_req;

  logic                             full;
  logic                             out_free;
  logic                             above, below, idx_wr;
  logic [mhb_pkg::CODE_W-1:0]       held_nxt;

  function automatic logic [mhb_pkg::MET_W-1:0] abs24(input logic [mhb_pkg::ROT_W-1:0] v);
    abs24 = v[mhb_pkg::ROT_W-1] ? (~v + 1'b1) : v;
  endfunction

  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid & in_tready;
  assign cfg_ready = 1'b1;
  assign cfg_acc   = cfg_valid & cfg_ready;

  assign ax          = abs24(in_tdata[23:0]);
  assign ay          = abs24(in_tdata[47:24]);
  assign az          = abs24(in_tdata[71:48]);
  assign in_interval = in_tdata[103:72];

  always_comb begin
    mx_nxt = ax;
    if (ay > mx_nxt) begin
      mx_nxt = ay;
    end
    if (az > mx_nxt) begin
      mx_nxt = az;
    end
  end

  // config
  assign code_in      = cfg_data[mhb_pkg::CODE_W-1:0];
  assign code_clamped = ({20'b0, code_in} > INDEX_MAX) ? mhb_pkg::CODE_W'(INDEX_MAX) : code_in;

  always_comb begin
    cfg_clear = 1'b0;
    if (cfg_acc) begin
      case (cfg_index)
        mhb_pkg::REG_BALL_RADIUS,
        mhb_pkg::REG_THRESHOLD_HIGH,
        mhb_pkg::REG_THRESHOLD_LOW,
        mhb_pkg::REG_VISIBLE_CODE,
        mhb_pkg::REG_BLANK_CODE: cfg_clear = 1'b1;
        default:                 cfg_clear = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      blank_en_r <= 1'b0;
      radius_r   <= 16'd1152;
      th_hi_r    <= 24'd2560;
      th_lo_r    <= 24'd1280;
      vis_code_r <= ({20'b0, 12'hFFF} > INDEX_MAX) ? mhb_pkg::CODE_W'(INDEX_MAX) : 12'hFFF;
      blk_code_r <= '0;
    end else if (cfg_acc) begin
      case (cfg_index)
        mhb_pkg::REG_BLANK_ENABLE:   blank_en_r <= cfg_data[0];
        mhb_pkg::REG_BALL_RADIUS:    radius_r   <= cfg_data[mhb_pkg::RAD_W-1:0];
        mhb_pkg::REG_THRESHOLD_HIGH: th_hi_r    <= cfg_data;
        mhb_pkg::REG_THRESHOLD_LOW:  th_lo_r    <= cfg_data;
        mhb_pkg::REG_VISIBLE_CODE:   vis_code_r <= code_clamped;
        mhb_pkg::REG_BLANK_CODE:     blk_code_r <= code_clamped;
        default: ;
      endcase
    end
  end

  // constant multiplier and shared divider
  assign mul_start = (state_r == S_PROD);
  assign mul_opd   = {{mhb_pkg::RAD_W{1'b0}}, mx_r} * {{mhb_pkg::MET_W{1'b0}}, radius_r};

  mhb_const_mul u_mul (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (mul_start),
    .operand (mul_opd),
    .done    (mul_done),
    .product (mul_prod)
  );

  always_comb begin
    div_start = 1'b0;
    div_req   = '0;
    if (state_r == S_MUL) begin
      div_start = mul_done;
      div_req.rem = {{(mhb_pkg::DIV_W - mhb_pkg::HI_W){1'b0}},
                     mul_prod[mhb_pkg::MUL_W-1:mhb_pkg::HI_LSB]};
      div_req.low = mul_prod[mhb_pkg::HI_LSB-1:mhb_pkg::NUM_SHIFT];
      div_req.dvs = interval_r;
    end else begin
      div_start = (state_r == S_MEANL) && (fill_r != '0);
      div_req.rem = {{(mhb_pkg::DIV_W - FILL_W){1'b0}}, sum_r[SUM_W-1:mhb_pkg::MET_W]};
      div_req.low = sum_r[mhb_pkg::MET_W-1:0];
      div_req.dvs = {{(mhb_pkg::DIV_W - FILL_W){1'b0}}, fill_r};
    end
  end

  mhb_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .req   (div_req),
    .done  (div_done),
    .quo   (div_quo)
  );

  // window ring
  assign full = (fill_r == FILL_W'(WINDOW_DEPTH));

  always_ff @(posedge clk) begin
    if (state_r == S_PUSH) begin
      win_mem[head_r] <= q_r;
    end
    old_r <= win_mem[head_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r  <= '0;
      head_r <= '0;
      fill_r <= '0;
    end else if (cfg_clear) begin
      sum_r  <= '0;
      head_r <= '0;
      fill_r <= '0;
    end else if (state_r == S_PUSH) begin
      sum_r <= sum_r - (full ? {{FILL_W{1'b0}}, old_r} : '0) + {{FILL_W{1'b0}}, q_r};
      if (!full) begin
        fill_r <= fill_r + 1'b1;
      end
      head_r <= (head_r == HEAD_W'(WINDOW_DEPTH - 1)) ? '0 : head_r + 1'b1;
    end
  end

  // item datapath
  always_ff @(posedge clk) begin
    if (in_acc) begin
      mx_r       <= mx_nxt;
      interval_r <= in_interval;
      taken_r    <= in_interval > mhb_pkg::MIN_INTERVAL;
    end
    if (state_r == S_QDIV && div_done) begin
      q_r <= div_quo;
    end
    if (state_r == S_MEANL) begin
      mean_r <= '0;
    end else if (state_r == S_MEAN && div_done) begin
      mean_r <= div_quo;
    end
  end

  // hysteresis decision
  assign above    = mean_r > th_hi_r;
  assign below    = mean_r < th_lo_r;
  assign idx_wr   = taken_r & blank_en_r & (above | below);
  assign held_nxt = idx_wr ? (above ? vis_code_r : blk_code_r) : held_r;
  assign out_free = !out_valid_r || out_tready;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:   if (in_acc) state_nxt = (in_interval > mhb_pkg::MIN_INTERVAL) ? S_PROD : S_MEANL;
      S_PROD:   state_nxt = S_MUL;
      S_MUL:    if (mul_done) state_nxt = S_QDIV;
      S_QDIV:   if (div_done) state_nxt = S_PUSH;
      S_PUSH:   state_nxt = S_MEANL;
      S_MEANL:  state_nxt = (fill_r != '0) ? S_MEAN : S_DECIDE;
      S_MEAN:   if (div_done) state_nxt = S_DECIDE;
      S_DECIDE: if (out_free) state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      held_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_DECIDE && out_free) begin
        held_r      <= held_nxt;
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_DECIDE && out_free) begin
      out_data_r <= {2'b00, idx_wr, held_nxt, mean_r, taken_r};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule
